>>> design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: table geometry,
// request and response items, table entry layout and status codes.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS = 128;
	localparam int SIZE_BITS  = 16;
	localparam int STORE_BITS = 24;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = 8;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_ALLOC    = 3'd0,
		ST_FREED    = 3'd1,
		ST_FULL     = 3'd2,
		ST_ALREADY  = 3'd3,
		ST_NOTFOUND = 3'd4
	} ffba_status_t;

	typedef struct packed {
		logic                 cmd;
		logic [SIZE_BITS-1:0] req_size;
		logic [CNT_W-1:0]     block_address;
	} ffba_req_t;

	typedef struct packed {
		ffba_status_t     status;
		logic [CNT_W-1:0] result_address;
		logic [CNT_W-1:0] block_count;
	} ffba_rsp_t;

	typedef struct packed {
		logic                  free;
		logic [STORE_BITS-1:0] size;
	} ffba_entry_t;

endpackage

>>> design/ffba_engine.sv
// ----------------------------------------------------------------------------
// ffba_engine
// Sequencer, block table memory and one shared add/subtract unit. Scans the
// table for a fit, reads the neighbors of a freed block, merges sizes and
// moves entries up or down one per cycle.
// ----------------------------------------------------------------------------
module ffba_engine
	import ffba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ffba_req_t req,
	output logic      idle,
	output logic      done,
	output ffba_rsp_t rsp,
	input  logic      rsp_take
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SCAN  = 10'b0000000010,
		S_FRD   = 10'b0000000100,
		S_MRG1  = 10'b0000001000,
		S_MRG2  = 10'b0000010000,
		S_SHIFT = 10'b0000100000,
		S_SPL1  = 10'b0001000000,
		S_SPL2  = 10'b0010000000,
		S_FWR   = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	localparam int SUM_W = STORE_BITS + 1;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SIZE_BITS-1:0] req_q;
	ffba_status_t         status_q;
	logic [CNT_W-1:0]     res_addr_q;

	// Scan bookkeeping.
	logic [CNT_W-1:0] idx_q;
	logic             chk_v_q;
	logic [IDX_W-1:0] chk_idx_q;
	logic [IDX_W-1:0] hit_q;
	logic             split_q;
	logic [STORE_BITS-1:0] rem_q;

	// Free bookkeeping.
	logic [IDX_W-1:0]      pos_q;
	logic [1:0]            fstep_q;
	logic                  nxt_ok_q;
	logic                  nxt_free_q;
	logic                  prv_free_q;
	logic [STORE_BITS-1:0] cur_q;
	logic [STORE_BITS-1:0] nxt_q;
	logic [STORE_BITS-1:0] prv_q;
	logic [STORE_BITS-1:0] acc_q;
	logic [IDX_W-1:0]      base_q;
	logic [1:0]            gap_q;

	// Entry mover.
	logic             sh_up_q;
	logic [CNT_W-1:0] sh_src_q;
	logic [CNT_W-1:0] sh_last_q;
	logic             pend_v_q;
	logic [IDX_W-1:0] pend_dst_q;

	// Table memory.
	ffba_entry_t      mem [MAX_BLOCKS];
	ffba_entry_t      rd_data_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	ffba_entry_t      wr_data;

	// Shared add/subtract unit.
	logic [SUM_W-1:0]      op_a;
	logic [SUM_W-1:0]      op_b;
	logic                  op_sub;
	logic [SUM_W-1:0]      sum;
	logic [STORE_BITS-1:0] sat;

	logic scan_hit;
	logic scan_more;
	logic sh_more;
	logic [CNT_W-1:0] addr_ext;

	always_comb begin
		op_sub = 1'b0;
		op_a   = {1'b0, acc_q};
		op_b   = prv_free_q ? {1'b0, prv_q} : '0;
		case (state_q)
			S_SCAN: begin
				op_sub = 1'b1;
				op_a   = {1'b0, rd_data_q.size};
				op_b   = SUM_W'(req_q);
			end
			S_MRG1: begin
				op_a = {1'b0, cur_q};
				op_b = nxt_free_q ? {1'b0, nxt_q} : '0;
			end
			default: ;
		endcase
	end

	assign sum = op_a + (op_b ^ {SUM_W{op_sub}}) + SUM_W'(op_sub);
	assign sat = sum[SUM_W-1] ? {STORE_BITS{1'b1}} : sum[STORE_BITS-1:0];

	// On subtraction the top bit of the sum is the borrow, set when a < b.
	assign scan_hit  = chk_v_q && rd_data_q.free && !sum[SUM_W-1];
	assign scan_more = idx_q < cnt_q;
	assign sh_more   = sh_up_q ? (sh_src_q >= sh_last_q) : (sh_src_q < cnt_q);
	assign addr_ext  = CNT_W'(hit_q) + CNT_W'(1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_data = '{free: 1'b0, size: STORE_BITS'(req_q)};
		case (state_q)
			S_SCAN: begin
				if (!scan_hit) begin
					if (scan_more) begin
						rd_en = 1'b1;
					end else begin
						wr_en = 1'b1;
					end
				end
			end
			S_FRD: begin
				rd_en = 1'b1;
				case (fstep_q)
					2'd0:    rd_addr = pos_q;
					2'd1:    rd_addr = pos_q + IDX_W'(1);
					default: rd_addr = pos_q - IDX_W'(1);
				endcase
			end
			S_SHIFT: begin
				rd_en   = sh_more;
				rd_addr = sh_src_q[IDX_W-1:0];
				wr_en   = pend_v_q;
				wr_addr = pend_dst_q;
				wr_data = rd_data_q;
			end
			S_SPL1: begin
				wr_en   = 1'b1;
				wr_addr = hit_q + IDX_W'(1);
				wr_data = '{free: 1'b1, size: rem_q};
			end
			S_SPL2: begin
				wr_en   = 1'b1;
				wr_addr = hit_q;
			end
			S_FWR: begin
				wr_en   = 1'b1;
				wr_addr = base_q;
				wr_data = '{free: 1'b1, size: acc_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			chk_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
			fstep_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q      <= req.req_size;
						res_addr_q <= '0;
						if (req.cmd == CMD_ALLOC) begin
							if (cnt_q == CNT_W'(MAX_BLOCKS)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								idx_q   <= '0;
								chk_v_q <= 1'b0;
								state_q <= S_SCAN;
							end
						end else begin
							if (req.block_address == '0 || req.block_address > cnt_q) begin
								status_q <= ST_NOTFOUND;
								state_q  <= S_DONE;
							end else begin
								pos_q    <= IDX_W'(req.block_address - CNT_W'(1));
								nxt_ok_q <= req.block_address < cnt_q;
								fstep_q  <= '0;
								state_q  <= S_FRD;
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						hit_q   <= chk_idx_q;
						rem_q   <= sum[STORE_BITS-1:0];
						chk_v_q <= 1'b0;
						if (sum[STORE_BITS-1:0] == '0) begin
							split_q <= 1'b0;
							state_q <= S_SPL2;
						end else begin
							// Open a hole right after the hit for the free remainder.
							split_q   <= 1'b1;
							sh_up_q   <= 1'b1;
							sh_src_q  <= cnt_q - CNT_W'(1);
							sh_last_q <= CNT_W'(chk_idx_q) + CNT_W'(1);
							pend_v_q  <= 1'b0;
							state_q   <= S_SHIFT;
						end
					end else if (scan_more) begin
						chk_v_q   <= 1'b1;
						chk_idx_q <= idx_q[IDX_W-1:0];
						idx_q     <= idx_q + CNT_W'(1);
					end else begin
						chk_v_q    <= 1'b0;
						cnt_q      <= cnt_q + CNT_W'(1);
						res_addr_q <= cnt_q + CNT_W'(1);
						status_q   <= ST_ALLOC;
						state_q    <= S_DONE;
					end
				end
				S_FRD: begin
					fstep_q <= fstep_q + 2'd1;
					case (fstep_q)
						2'd1: begin
							cur_q <= rd_data_q.size;
							if (rd_data_q.free) begin
								status_q <= ST_ALREADY;
								state_q  <= S_DONE;
							end
						end
						2'd2: begin
							nxt_q      <= rd_data_q.size;
							nxt_free_q <= nxt_ok_q && rd_data_q.free;
						end
						2'd3: begin
							prv_q      <= rd_data_q.size;
							prv_free_q <= (pos_q != '0) && rd_data_q.free;
							state_q    <= S_MRG1;
						end
						default: ;
					endcase
				end
				S_MRG1: begin
					acc_q   <= sat;
					state_q <= S_MRG2;
				end
				S_MRG2: begin
					acc_q  <= sat;
					gap_q  <= 2'(nxt_free_q) + 2'(prv_free_q);
					base_q <= prv_free_q ? pos_q - IDX_W'(1) : pos_q;
					if (nxt_free_q || prv_free_q) begin
						// Close the gap left by the absorbed neighbors.
						sh_up_q  <= 1'b0;
						sh_src_q <= CNT_W'(pos_q) + CNT_W'(1) + CNT_W'(nxt_free_q);
						pend_v_q <= 1'b0;
						state_q  <= S_SHIFT;
					end else begin
						state_q <= S_FWR;
					end
				end
				S_SHIFT: begin
					if (sh_more) begin
						pend_v_q <= 1'b1;
						if (sh_up_q) begin
							pend_dst_q <= IDX_W'(sh_src_q + CNT_W'(1));
							sh_src_q   <= sh_src_q - CNT_W'(1);
						end else begin
							pend_dst_q <= IDX_W'(sh_src_q - CNT_W'(gap_q));
							sh_src_q   <= sh_src_q + CNT_W'(1);
						end
					end else begin
						pend_v_q <= 1'b0;
						state_q  <= sh_up_q ? S_SPL1 : S_FWR;
					end
				end
				S_SPL1: begin
					state_q <= S_SPL2;
				end
				S_SPL2: begin
					if (split_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					res_addr_q <= addr_ext;
					status_q   <= ST_ALLOC;
					state_q    <= S_DONE;
				end
				S_FWR: begin
					cnt_q    <= cnt_q - CNT_W'(gap_q);
					status_q <= ST_FREED;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (rsp_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle = state_q == S_IDLE;
	assign done = state_q == S_DONE;
	assign rsp  = '{status: status_q, result_address: res_addr_q, block_count: cnt_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_BLOCKS))
		else $error("entry count beyond table size");

	a_alloc_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_ALLOC) |-> (res_addr_q != '0 && res_addr_q <= cnt_q))
		else $error("allocated address outside the table");

	a_err_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q != ST_ALLOC) |-> res_addr_q == '0)
		else $error("address reported on a non-allocate result");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(idle || done) |-> !wr_en)
		else $error("table written outside an operation");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && !start) |=> $stable(cnt_q) && idle)
		else $error("entry count changed while idle");

endmodule

>>> design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over an ordered block table, with split on allocate and
// merge with free neighbors on free. Holds the response register in front of
// the sequencing engine.
//
//   channel | direction | payload    | handshake
//   req     | in        | ffba_req_t | req_valid / req_ready
//   rsp     | out       | ffba_rsp_t | rsp_valid / rsp_ready
//
// One item at a time. An allocate that finds no fit scans all N entries and
// appends; a fit at index h ends the scan there, and a split moves every
// later entry up one per cycle. A free that merges moves every later entry
// down one per cycle. The table memory, with one read and one write port,
// reads one entry per cycle.
// Reset clears the entry count; table contents need no clearing.
// A result waiting in the response register does not block the next item;
// only the one after that waits until the response is taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
	import ffba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  ffba_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output ffba_rsp_t rsp
);

	logic      eng_idle;
	logic      eng_done;
	ffba_rsp_t eng_rsp;
	logic      rsp_take;
	logic      rsp_valid_q;
	ffba_rsp_t rsp_q;

	assign req_ready = eng_idle;
	assign rsp_take  = eng_done && (!rsp_valid_q || rsp_ready);

	ffba_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_valid && req_ready),
		.req      (req),
		.idle     (eng_idle),
		.done     (eng_done),
		.rsp      (eng_rsp),
		.rsp_take (rsp_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			rsp_q <= eng_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
